// File: rtl/core/cpnf_pkg.sv
// Shared constants, types and command/status bundles of the clipped pixel neighbor fill block
`timescale 1ns / 1ps
package cpnf_pkg;

	// sizing
	localparam int MAX_RADIUS = 3;
	localparam int MAX_WIDTH  = 2048;
	localparam int PIXEL_BITS = 32;
	localparam int MAX_HEIGHT = 4096;

	localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
	localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SLOT_W     = $clog2(STORE_ROWS);
	localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
	localparam int SPAN_W     = $clog2(2 * MAX_RADIUS + 1);
	localparam int WIN_MAX    = STORE_ROWS * STORE_ROWS;
	localparam int CNT_W      = $clog2(WIN_MAX + 1);
	localparam int SUM_W      = PIXEL_BITS + CNT_W;
	localparam int DCNT_W     = $clog2(SUM_W + 1);
	localparam int CMP_W      = (PIXEL_BITS > 32) ? PIXEL_BITS : 32;

	// row modulo by reciprocal multiply
	localparam int MOD_SHIFT  = ROW_W + SLOT_W;
	localparam int MOD_RECIP  = (2 ** MOD_SHIFT + STORE_ROWS - 1) / STORE_ROWS;
	localparam int PROD_W     = ROW_W + MOD_SHIFT + 1;

	// register field widths
	localparam int CLIP_W     = 32;
	localparam int RADCFG_W   = 2;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int AVG_W      = 23;
	localparam int AVGOUT_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP   = 3'd0,
		REG_RADIUS = 3'd1,
		REG_MATCH  = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic accept;
		logic mod_mul;
		logic mod_rem;
		logic pix_write;
		logic center_read;
		logic win_init;
		logic win_read;
		logic div_start;
		logic div_step;
		logic write_back;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic center_ok;
		logic center_hit;
		logic win_last;
		logic div_done;
		logic zero_cnt;
		logic out_block;
	} status_t;

endpackage

// File: rtl/core/clipped_pixel_neighbor_fill.sv
// Top level of the clipped pixel neighbor fill block
`timescale 1ns / 1ps
// Usage:
// - input channel: one raster-order pixel (signed Q16.16) per item on
//   pixel_value, taken when in_valid is high and in_stall is low
// - output channel: a result item for each replaced pixel (column, row,
//   new value, averaged flag); the last pixel of a plane always gives an
//   item, carrying frame_done; held while out_stall is high
// - configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are high (ready is always high); write only while the block is idle
// Sequence per item, set by the sequencer over the line store: the row slot
//   comes from a reciprocal multiply, the pixel is written to the store and,
//   if the center is in range, the center is read back and tested; a replaced
//   center then sweeps the window, reading one store entry per cycle, and runs
//   the divider, producing one quotient bit per cycle; the divider is skipped
//   when no window pixel reaches the clip level
// Results appear in the cycle after the item finishes; a result waits in the
// output register, and the next item is taken meanwhile, only stalling at its
// own result if the earlier one is still unclaimed.
// Reset clears the counters, configuration registers and flags to their defaults; the line store
// needs no clearing since every read entry was written earlier in the plane.
module clipped_pixel_neighbor_fill (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [cpnf_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cpnf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cpnf_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cpnf_pkg::COL_W-1:0]            pixel_column,
	output logic [cpnf_pkg::ROW_W-1:0]            pixel_row,
	output logic signed [cpnf_pkg::PIXEL_BITS-1:0] new_value,
	output logic                                  was_averaged,
	output logic                                  has_pixel,
	output logic                                  frame_done,
	output logic [cpnf_pkg::AVGOUT_W-1:0]         averaged_count
);

	cpnf_pkg::cmd_t    cmd;
	cpnf_pkg::status_t sts;

	cpnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpnf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pixel_value    (pixel_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_column   (pixel_column),
		.pixel_row      (pixel_row),
		.new_value      (new_value),
		.was_averaged   (was_averaged),
		.has_pixel      (has_pixel),
		.frame_done     (frame_done),
		.averaged_count (averaged_count)
	);

endmodule

// File: rtl/core/cpnf_ctrl.sv
// Sequencer for one pixel item: row slot, store, center test, window sweep, divide, write back, result
`timescale 1ns / 1ps
module cpnf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpnf_pkg::status_t sts,
	output cpnf_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_REM, ST_WRITE, ST_RDC, ST_CHK, ST_ACC,
		ST_DRAIN, ST_DSTART, ST_DIV, ST_WB, ST_FIN
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_REM;
				ST_REM:    state_q <= ST_WRITE;
				ST_WRITE:  state_q <= sts.center_ok ? ST_RDC : ST_FIN;
				ST_RDC:    state_q <= ST_CHK;
				ST_CHK:    state_q <= sts.center_hit ? ST_ACC : ST_FIN;
				ST_ACC:    if (sts.win_last) state_q <= ST_DRAIN;
				ST_DRAIN:  state_q <= ST_DSTART;
				ST_DSTART: state_q <= sts.zero_cnt ? ST_WB : ST_DIV;
				ST_DIV:    if (sts.div_done) state_q <= ST_WB;
				ST_WB:     state_q <= ST_FIN;
				ST_FIN:    if (!sts.out_block) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.accept      = in_valid;
			ST_MUL:    cmd.mod_mul     = 1'b1;
			ST_REM:    cmd.mod_rem     = 1'b1;
			ST_WRITE:  cmd.pix_write   = 1'b1;
			ST_RDC:    cmd.center_read = 1'b1;
			ST_CHK:    cmd.win_init    = sts.center_hit;
			ST_ACC:    cmd.win_read    = 1'b1;
			ST_DRAIN:  cmd = '0;
			ST_DSTART: cmd.div_start   = 1'b1;
			ST_DIV:    cmd.div_step    = !sts.div_done;
			ST_WB:     cmd.write_back  = 1'b1;
			ST_FIN:    cmd.finish      = !sts.out_block;
			default:   cmd = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: rtl/core/cpnf_datapath.sv
// Configuration registers, line store, counters, window accumulator, serial divider and output register
`timescale 1ns / 1ps
module cpnf_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpnf_pkg::cmd_t                        cmd,
	output cpnf_pkg::status_t                     sts,
	input  logic signed [cpnf_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cpnf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cpnf_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cpnf_pkg::COL_W-1:0]            pixel_column,
	output logic [cpnf_pkg::ROW_W-1:0]            pixel_row,
	output logic signed [cpnf_pkg::PIXEL_BITS-1:0] new_value,
	output logic                                  was_averaged,
	output logic                                  has_pixel,
	output logic                                  frame_done,
	output logic [cpnf_pkg::AVGOUT_W-1:0]         averaged_count
);

	localparam int PB = cpnf_pkg::PIXEL_BITS;

	// configuration registers
	logic signed [cpnf_pkg::CLIP_W-1:0] clip_q;
	logic [cpnf_pkg::RADCFG_W-1:0]      radius_q;
	logic                               match_q;
	logic [cpnf_pkg::FW_W-1:0]          width_q;
	logic [cpnf_pkg::FH_W-1:0]          height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= '0;
			radius_q <= cpnf_pkg::RADCFG_W'(1);
			match_q  <= 1'b1;
			width_q  <= cpnf_pkg::FW_W'(2048);
			height_q <= cpnf_pkg::FH_W'(2048);
		end else if (cfg_valid) begin
			case (cfg_index)
				cpnf_pkg::REG_CLIP:   clip_q   <= cfg_data[cpnf_pkg::CLIP_W-1:0];
				cpnf_pkg::REG_RADIUS: radius_q <= cfg_data[cpnf_pkg::RADCFG_W-1:0];
				cpnf_pkg::REG_MATCH:  match_q  <= cfg_data[0];
				cpnf_pkg::REG_WIDTH:  width_q  <= cfg_data[cpnf_pkg::FW_W-1:0];
				cpnf_pkg::REG_HEIGHT: height_q <= cfg_data[cpnf_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective radius, width and height
	logic [cpnf_pkg::RAD_W-1:0]   r_eff;
	logic [cpnf_pkg::COL_W:0]     w_eff;
	logic [cpnf_pkg::ROW_W:0]     h_eff;
	logic [cpnf_pkg::SPAN_W-1:0]  span;
	logic signed [cpnf_pkg::CMP_W-1:0] clip_x;

	always_comb begin
		if (radius_q == '0)
			r_eff = cpnf_pkg::RAD_W'(1);
		else if (32'(radius_q) > cpnf_pkg::MAX_RADIUS)
			r_eff = cpnf_pkg::RAD_W'(cpnf_pkg::MAX_RADIUS);
		else
			r_eff = cpnf_pkg::RAD_W'(radius_q);
		if (width_q == '0)
			w_eff = (cpnf_pkg::COL_W+1)'(1);
		else if (32'(width_q) > cpnf_pkg::MAX_WIDTH)
			w_eff = (cpnf_pkg::COL_W+1)'(cpnf_pkg::MAX_WIDTH);
		else
			w_eff = (cpnf_pkg::COL_W+1)'(width_q);
		if (height_q == '0)
			h_eff = (cpnf_pkg::ROW_W+1)'(1);
		else if (32'(height_q) > cpnf_pkg::MAX_HEIGHT)
			h_eff = (cpnf_pkg::ROW_W+1)'(cpnf_pkg::MAX_HEIGHT);
		else
			h_eff = (cpnf_pkg::ROW_W+1)'(height_q);
		span   = cpnf_pkg::SPAN_W'({r_eff, 1'b0});
		clip_x = cpnf_pkg::CMP_W'(clip_q);
	end

	// position counters and the latched item
	logic [cpnf_pkg::COL_W-1:0] col_ctr_q, col_q;
	logic [cpnf_pkg::ROW_W-1:0] row_ctr_q, row_q;
	logic signed [PB-1:0]       pix_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= pixel_value;
			col_q <= ({1'b0, col_ctr_q} >= w_eff) ? cpnf_pkg::COL_W'(w_eff - 1'b1) : col_ctr_q;
			row_q <= ({1'b0, row_ctr_q} >= h_eff) ? cpnf_pkg::ROW_W'(h_eff - 1'b1) : row_ctr_q;
		end
	end

	logic last_col, last_row, done;
	assign last_col = ({1'b0, col_q} + 1'b1) >= w_eff;
	assign last_row = ({1'b0, row_q} + 1'b1) >= h_eff;
	assign done     = last_col && last_row;

	// row slot: row modulo store rows by reciprocal multiply
	logic [cpnf_pkg::PROD_W-1:0] prod_q;
	logic [cpnf_pkg::SLOT_W-1:0] slot_q;
	logic [cpnf_pkg::ROW_W-1:0]  quo7;

	assign quo7 = cpnf_pkg::ROW_W'(prod_q >> cpnf_pkg::MOD_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.mod_mul)
			prod_q <= cpnf_pkg::PROD_W'(row_q) * cpnf_pkg::PROD_W'(cpnf_pkg::MOD_RECIP);
		if (cmd.mod_rem)
			slot_q <= cpnf_pkg::SLOT_W'(row_q - cpnf_pkg::ROW_W'(quo7 * cpnf_pkg::STORE_ROWS));
	end

	// slots of the top window row and of the center row
	logic [cpnf_pkg::SLOT_W:0]   base_sum, cen_sum;
	logic [cpnf_pkg::SLOT_W-1:0] base_slot, cen_slot;
	always_comb begin
		if ((cpnf_pkg::SLOT_W+1)'(slot_q) >= (cpnf_pkg::SLOT_W+1)'(span))
			base_sum = (cpnf_pkg::SLOT_W+1)'(slot_q) - (cpnf_pkg::SLOT_W+1)'(span);
		else
			base_sum = (cpnf_pkg::SLOT_W+1)'(slot_q) + (cpnf_pkg::SLOT_W+1)'(cpnf_pkg::STORE_ROWS)
				- (cpnf_pkg::SLOT_W+1)'(span);
		base_slot = cpnf_pkg::SLOT_W'(base_sum);
		cen_sum   = (cpnf_pkg::SLOT_W+1)'(base_slot) + (cpnf_pkg::SLOT_W+1)'(r_eff);
		if (cen_sum >= (cpnf_pkg::SLOT_W+1)'(cpnf_pkg::STORE_ROWS))
			cen_sum = cen_sum - (cpnf_pkg::SLOT_W+1)'(cpnf_pkg::STORE_ROWS);
		cen_slot = cpnf_pkg::SLOT_W'(cen_sum);
	end

	logic [cpnf_pkg::COL_W-1:0] cx;
	logic [cpnf_pkg::ROW_W-1:0] cy;
	assign cx = col_q - cpnf_pkg::COL_W'(r_eff);
	assign cy = row_q - cpnf_pkg::ROW_W'(r_eff);

	// window sweep counters
	logic [cpnf_pkg::SPAN_W-1:0] wx_q, wy_q;
	logic [cpnf_pkg::SLOT_W-1:0] ws_q;
	logic                        rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_q <= 1'b0;
		else
			rd_vld_q <= cmd.win_read;
	end

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			wx_q <= '0;
			wy_q <= '0;
			ws_q <= base_slot;
		end else if (cmd.win_read) begin
			if (wx_q == span) begin
				wx_q <= '0;
				wy_q <= wy_q + 1'b1;
				ws_q <= (32'(ws_q) == cpnf_pkg::STORE_ROWS - 1) ? '0 : ws_q + 1'b1;
			end else begin
				wx_q <= wx_q + 1'b1;
			end
		end
	end

	// store addresses
	logic [cpnf_pkg::ADDR_W-1:0] pix_addr, cen_addr, win_addr, rd_addr, wr_addr;
	logic [cpnf_pkg::COL_W-1:0]  win_col;
	assign win_col  = col_q - cpnf_pkg::COL_W'(span) + cpnf_pkg::COL_W'(wx_q);
	assign pix_addr = cpnf_pkg::ADDR_W'(slot_q * cpnf_pkg::MAX_WIDTH) + cpnf_pkg::ADDR_W'(col_q);
	assign cen_addr = cpnf_pkg::ADDR_W'(cen_slot * cpnf_pkg::MAX_WIDTH) + cpnf_pkg::ADDR_W'(cx);
	assign win_addr = cpnf_pkg::ADDR_W'(ws_q * cpnf_pkg::MAX_WIDTH) + cpnf_pkg::ADDR_W'(win_col);
	assign rd_addr  = cmd.center_read ? cen_addr : win_addr;
	assign wr_addr  = cmd.pix_write ? pix_addr : cen_addr;

	// line store
	logic signed [PB-1:0] store_mem [cpnf_pkg::DEPTH];
	logic signed [PB-1:0] rd_q;
	logic signed [PB-1:0] wr_data;
	logic signed [PB-1:0] fill_value;

	assign wr_data = cmd.pix_write ? pix_q : fill_value;

	always_ff @(posedge clk) begin
		if (cmd.pix_write || cmd.write_back)
			store_mem[wr_addr] <= wr_data;
		rd_q <= store_mem[rd_addr];
	end

	logic signed [cpnf_pkg::CMP_W-1:0] rd_x;
	assign rd_x = cpnf_pkg::CMP_W'(rd_q);

	// accumulate qualifying window pixels
	logic signed [cpnf_pkg::SUM_W-1:0] sum_q;
	logic [cpnf_pkg::CNT_W-1:0]        cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rd_vld_q && (rd_x >= clip_x)) begin
			sum_q <= sum_q + cpnf_pkg::SUM_W'(rd_q);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// restoring divider on the magnitude, one quotient bit per cycle
	logic [cpnf_pkg::SUM_W-1:0]  dvd_q;
	logic [cpnf_pkg::CNT_W-1:0]  rem_q;
	logic [cpnf_pkg::DCNT_W-1:0] dcnt_q;
	logic                        neg_q;
	logic [cpnf_pkg::CNT_W:0]    rem_sh;
	logic                        qbit;
	logic [cpnf_pkg::SUM_W-1:0]  quo_signed;

	assign rem_sh = {rem_q, dvd_q[cpnf_pkg::SUM_W-1]};
	assign qbit   = rem_sh >= (cpnf_pkg::CNT_W+1)'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q  <= sum_q[cpnf_pkg::SUM_W-1] ? cpnf_pkg::SUM_W'(-sum_q) : sum_q;
			neg_q  <= sum_q[cpnf_pkg::SUM_W-1];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[cpnf_pkg::SUM_W-2:0], qbit};
			rem_q  <= cpnf_pkg::CNT_W'(qbit ? rem_sh - (cpnf_pkg::CNT_W+1)'(cnt_q) : rem_sh);
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	assign quo_signed = neg_q ? cpnf_pkg::SUM_W'(-dvd_q) : dvd_q;
	assign fill_value = (cnt_q == '0) ? PB'(clip_q) : quo_signed[PB-1:0];

	// per-item replacement flags and plane counter
	logic                       has_q, avg_q;
	logic [cpnf_pkg::AVG_W-1:0] avg_ctr_q;
	logic                       need_out;

	assign need_out = has_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q     <= 1'b0;
			avg_q     <= 1'b0;
			avg_ctr_q <= '0;
			col_ctr_q <= '0;
			row_ctr_q <= '0;
		end else begin
			if (cmd.accept) begin
				has_q <= 1'b0;
				avg_q <= 1'b0;
			end
			if (cmd.write_back) begin
				has_q <= 1'b1;
				avg_q <= (cnt_q != '0);
				if (cnt_q != '0)
					avg_ctr_q <= avg_ctr_q + 1'b1;
			end
			if (cmd.finish) begin
				if (done)
					avg_ctr_q <= '0;
				if (last_col) begin
					col_ctr_q <= '0;
					row_ctr_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_ctr_q <= col_q + 1'b1;
					row_ctr_q <= row_q;
				end
			end
		end
	end

	// output register
	logic                        out_valid_q;
	logic                        load_out;
	logic [cpnf_pkg::COL_W-1:0]  out_col_q;
	logic [cpnf_pkg::ROW_W-1:0]  out_row_q;
	logic signed [PB-1:0]        out_val_q;
	logic                        out_avg_q, out_has_q, out_done_q;
	logic [cpnf_pkg::AVG_W-1:0]  out_cnt_q;

	assign load_out = cmd.finish && need_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q  <= has_q ? cx : '0;
			out_row_q  <= has_q ? cy : '0;
			out_val_q  <= has_q ? fill_value : '0;
			out_avg_q  <= avg_q;
			out_has_q  <= has_q;
			out_done_q <= done;
			out_cnt_q  <= avg_ctr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_column   = out_col_q;
	assign pixel_row      = out_row_q;
	assign new_value      = out_val_q;
	assign was_averaged   = out_avg_q;
	assign has_pixel      = out_has_q;
	assign frame_done     = out_done_q;
	assign averaged_count = cpnf_pkg::AVGOUT_W'(out_cnt_q);

	// status back to the sequencer
	assign sts.center_ok  = (32'(col_q) >= 32'(span)) && (32'(row_q) >= 32'(span));
	assign sts.center_hit = (rd_x < clip_x) || (match_q && (rd_x == clip_x));
	assign sts.win_last   = (wx_q == span) && (wy_q == span);
	assign sts.div_done   = (32'(dcnt_q) == cpnf_pkg::SUM_W);
	assign sts.zero_cnt   = (cnt_q == '0);
	assign sts.out_block  = need_out && out_valid_q && out_stall;

`ifndef SYNTHESIS
	a_avg_has: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_avg_q |-> out_has_q)
		else $error("averaged result without a replacement");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> 32'(dcnt_q) < cpnf_pkg::SUM_W)
		else $error("divider stepped past its last bit");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_q |-> 32'(cnt_q) < cpnf_pkg::WIN_MAX)
		else $error("window count overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("pending result overwritten");
`endif

endmodule

// File: tb/tb_clipped_pixel_neighbor_fill.sv
// Self-checking testbench for the clipped pixel neighbor fill block
`timescale 1ns / 1ps
module tb_clipped_pixel_neighbor_fill;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 150;

	typedef struct packed {
		logic [cpnf_pkg::COL_W-1:0]             col;
		logic [cpnf_pkg::ROW_W-1:0]             row;
		logic signed [cpnf_pkg::PIXEL_BITS-1:0] value;
		logic                                   avg;
		logic                                   has;
		logic                                   done;
		logic [cpnf_pkg::AVGOUT_W-1:0]          count;
	} fill_result_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic signed [cpnf_pkg::PIXEL_BITS-1:0] pixel_value = '0;
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [cpnf_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [cpnf_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic [cpnf_pkg::COL_W-1:0]             pixel_column;
	logic [cpnf_pkg::ROW_W-1:0]             pixel_row;
	logic signed [cpnf_pkg::PIXEL_BITS-1:0] new_value;
	logic                                   was_averaged;
	logic                                   has_pixel;
	logic                                   frame_done;
	logic [cpnf_pkg::AVGOUT_W-1:0]          averaged_count;

	clipped_pixel_neighbor_fill u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_value(pixel_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_column(pixel_column), .pixel_row(pixel_row), .new_value(new_value),
		.was_averaged(was_averaged), .has_pixel(has_pixel), .frame_done(frame_done),
		.averaged_count(averaged_count)
	);

	always #4 clk = ~clk;

	// mirror of the block state
	logic signed [cpnf_pkg::PIXEL_BITS-1:0] line_store [cpnf_pkg::STORE_ROWS][cpnf_pkg::MAX_WIDTH];
	logic signed [cpnf_pkg::CLIP_W-1:0]     clip_q;
	logic [cpnf_pkg::RADCFG_W-1:0]          radius_q;
	logic                                   match_q;
	logic [cpnf_pkg::FW_W-1:0]              width_q;
	logic [cpnf_pkg::FH_W-1:0]              height_q;
	int unsigned                            col_q, row_q;
	logic [cpnf_pkg::AVG_W-1:0]             avg_cnt_q;

	fill_result_t pending_fills[$];
	int mismatches = 0;
	int send_idle_pct = 29;
	int recv_idle_pct = 65;
	int quiet_cycles = 0;

	// compute the result of one accepted pixel
	function automatic void predict_fill(input logic signed [cpnf_pkg::PIXEL_BITS-1:0] v);
		int unsigned r, w, h, col, row, cx, cy;
		longint cv, px, sum, cnt, newv;
		bit has, avg, done;
		fill_result_t e;
		r = (radius_q == 0) ? 1 :
			((radius_q > cpnf_pkg::MAX_RADIUS) ? cpnf_pkg::MAX_RADIUS : radius_q);
		w = (width_q == 0) ? 1 :
			((width_q > cpnf_pkg::MAX_WIDTH) ? cpnf_pkg::MAX_WIDTH : width_q);
		h = (height_q == 0) ? 1 :
			((height_q > cpnf_pkg::MAX_HEIGHT) ? cpnf_pkg::MAX_HEIGHT : height_q);
		col = (col_q >= w) ? w - 1 : col_q;
		row = (row_q >= h) ? h - 1 : row_q;
		has = 0; avg = 0; done = 0; cx = 0; cy = 0; newv = 0;
		line_store[row % cpnf_pkg::STORE_ROWS][col] = v;
		if (col >= 2 * r && row >= 2 * r) begin
			cx = col - r;
			cy = row - r;
			cv = line_store[cy % cpnf_pkg::STORE_ROWS][cx];
			if (cv < clip_q || (match_q && cv == clip_q)) begin
				sum = 0; cnt = 0;
				for (int unsigned yy = cy - r; yy <= cy + r; yy++)
					for (int unsigned xx = cx - r; xx <= cx + r; xx++) begin
						px = line_store[yy % cpnf_pkg::STORE_ROWS][xx];
						if (px >= clip_q) begin
							sum += px;
							cnt++;
						end
					end
				if (cnt > 0) begin
					newv = sum / cnt;
					avg = 1;
					avg_cnt_q = avg_cnt_q + 1'b1;
				end else begin
					newv = clip_q;
				end
				line_store[cy % cpnf_pkg::STORE_ROWS][cx] = cpnf_pkg::PIXEL_BITS'(newv);
				has = 1;
			end
		end
		if (col + 1 >= w) begin
			col_q = 0;
			if (row + 1 >= h) begin
				row_q = 0;
				done = 1;
			end else begin
				row_q = row + 1;
			end
		end else begin
			col_q = col + 1;
			row_q = row;
		end
		if (has || done) begin
			e.col   = has ? cpnf_pkg::COL_W'(cx) : '0;
			e.row   = has ? cpnf_pkg::ROW_W'(cy) : '0;
			e.value = has ? cpnf_pkg::PIXEL_BITS'(newv) : '0;
			e.avg   = avg;
			e.has   = has;
			e.done  = done;
			e.count = cpnf_pkg::AVGOUT_W'(avg_cnt_q);
			pending_fills.push_back(e);
		end
		if (done)
			avg_cnt_q = '0;
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// compare each result item against the oldest expectation
	always @(posedge clk) begin
		fill_result_t got, exp_r;
		if (out_valid && !out_stall) begin
			got = '{pixel_column, pixel_row, new_value, was_averaged, has_pixel,
				frame_done, averaged_count};
			if (pending_fills.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: col %0d row %0d value %0d done %0b",
						got.col, got.row, got.value, got.done);
			end else begin
				exp_r = pending_fills.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: col %0d row %0d val %0d avg %0b has %0b done %0b cnt %0d",
							exp_r.col, exp_r.row, exp_r.value, exp_r.avg, exp_r.has,
							exp_r.done, exp_r.count);
						$display("         got: col %0d row %0d val %0d avg %0b has %0b done %0b cnt %0d",
							got.col, got.row, got.value, got.avg, got.has,
							got.done, got.count);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// send one pixel item and predict its result
	task automatic send_pixel(input logic signed [cpnf_pkg::PIXEL_BITS-1:0] v);
		bit go;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= v;
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		predict_fill(v);
	endtask

	// wait until every expected item has come, then let the block settle
	task automatic drain_results();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_fills.size() != 0 && n < 10 * STALL_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_fills.size() != 0) begin
			mismatches++;
			pending_fills.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cpnf_pkg::reg_idx_t idx,
			input logic [cpnf_pkg::CFG_DATA_W-1:0] d);
		bit go;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do begin
			@(negedge clk);
			go = cfg_ready;
			@(posedge clk);
		end while (!go);
		cfg_valid <= 1'b0;
		case (idx)
			cpnf_pkg::REG_CLIP:   clip_q   = d[cpnf_pkg::CLIP_W-1:0];
			cpnf_pkg::REG_RADIUS: radius_q = d[cpnf_pkg::RADCFG_W-1:0];
			cpnf_pkg::REG_MATCH:  match_q  = d[0];
			cpnf_pkg::REG_WIDTH:  width_q  = d[cpnf_pkg::FW_W-1:0];
			cpnf_pkg::REG_HEIGHT: height_q = d[cpnf_pkg::FH_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [cpnf_pkg::CFG_DATA_W-1:0] clip, input int rad,
			input bit match, input int w, input int h);
		write_reg(cpnf_pkg::REG_CLIP, clip);
		write_reg(cpnf_pkg::REG_RADIUS, rad);
		write_reg(cpnf_pkg::REG_MATCH, match);
		write_reg(cpnf_pkg::REG_WIDTH, w);
		write_reg(cpnf_pkg::REG_HEIGHT, h);
	endtask

	// pixel mix weighted around the clip level
	function automatic logic signed [cpnf_pkg::PIXEL_BITS-1:0] pick_pixel();
		case ($urandom_range(9))
			0:       return clip_q;
			1, 2:    return clip_q + $urandom_range(40000);
			3, 4:    return clip_q - $urandom_range(40000);
			5:       return 32'sh8000_0000;
			6:       return 32'sh7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_pixel());
	endtask

	// small hand-built planes: clip ties, extremes, no qualifying neighbor
	task automatic test_directed_planes();
		logic signed [cpnf_pkg::PIXEL_BITS-1:0] grid [20] = '{
			100, 200, -5, 32'sh7FFF_FFFF, 0,
			50, 0, -1, 32'sh8000_0000, 7,
			-3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 0, 1,
			9, -9, 3, 0, 32'sh8000_0000};
		set_frame(0, 0, 1, 5, 4);
		foreach (grid[i]) send_pixel(grid[i]);
		drain_results();
		// all neighbors below the clip, replacement on the last pixel
		set_frame(32'h0001_0000, 1, 0, 3, 3);
		repeat (9) send_pixel(-7);
		drain_results();
		// negative mean truncates toward zero
		set_frame(32'hFFFF_0000, 1, 1, 3, 3);
		send_pixel(-3); send_pixel(-4); send_pixel(-70000);
		send_pixel(-2); send_pixel(-65536); send_pixel(-6);
		send_pixel(-70000); send_pixel(-1); send_pixel(-70000);
		drain_results();
	endtask

	// width and height at zero and above their limits, cut short mid-plane
	task automatic test_size_limits();
		set_frame(32'h8000_0000, 2, 1, 0, 5);
		send_frame(5);
		drain_results();
		// oversized width, then shrunk to the column counter
		set_frame(32'h7FFF_FFFF, 3, 0, 4095, 1);
		send_frame(40);
		drain_results();
		write_reg(cpnf_pkg::REG_WIDTH, 40);
		send_frame(1);
		drain_results();
		// oversized height, then shrunk below the row counter
		set_frame(32'h0000_0000, 1, 1, 1, 8191);
		send_frame(20);
		drain_results();
		write_reg(cpnf_pkg::REG_HEIGHT, 5);
		send_frame(1);
		drain_results();
		set_frame(32'h0000_0000, 3, 1, 7, 0);
		send_frame(7);
		drain_results();
	endtask

	// clip and match change in the middle of a plane
	task automatic test_midplane_clip_change();
		set_frame(32'h0000_8000, 2, 1, 9, 8);
		send_frame(30);
		drain_results();
		write_reg(cpnf_pkg::REG_CLIP, 32'hFFFF_C000);
		write_reg(cpnf_pkg::REG_MATCH, 0);
		send_frame(42);
		drain_results();
	endtask

	// random planes over three idling regimes
	task automatic test_random_planes();
		int rad, w, h;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 65 : 0;
			recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 29 : 0;
			for (int k = 0; k < 6; k++) begin
				rad = $urandom_range(1, 3);
				w = $urandom_range(2 * rad + 1, 14);
				h = $urandom_range(2 * rad + 1, 10);
				set_frame(($urandom_range(3) == 0) ? $urandom : $urandom_range(200000) - 100000,
					rad, $urandom_range(1), w, h);
				repeat ((k == 5) ? 2 : 1) send_frame(w * h);
				drain_results();
			end
		end
	endtask

	initial begin
		avg_cnt_q = '0; col_q = 0; row_q = 0;
		clip_q = '0; radius_q = 1; match_q = 1; width_q = 2048; height_q = 2048;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_planes();
		test_size_limits();
		test_midplane_clip_change();
		test_random_planes();
		drain_results();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
